// File: hdl/multimode_pid_controller_top_assert.svh
// assertion macros for the multimode pid controller
// used by multimode_pid_controller_top; expects clk and rst_n in scope
`ifndef MULTIMODE_PID_CONTROLLER_TOP_ASSERT_SVH
`define MULTIMODE_PID_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define MPID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpid assertion failed");
// next-cycle implication, disabled in reset
`define MPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpid assertion failed");
`else
`define MPID_ASSERT_NOW(lbl, ante, cons)
`define MPID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/mpid_pkg.sv
// shared types and constants for the multimode pid controller
// no dependencies
package mpid_pkg;

  localparam int DATA_W      = 16;
  localparam int ERR_W       = 17;
  localparam int SUM_W       = 24;
  localparam int DLIM_W      = 15;
  localparam int ILIM_W      = 23;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam logic [DLIM_W-1:0] DLIM_RST = 15'h7fff;
  localparam logic [ILIM_W-1:0] ILIM_RST = 23'h7fffff;

  typedef enum logic [MODE_W-1:0] {
    MODE_INC      = 3'd0,
    MODE_POS      = 3'd1,
    MODE_TRAP_INC = 3'd2,
    MODE_TRAP_POS = 3'd3,
    MODE_POS_RATE = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_DRIVE_LIM  = 3'd4,
    REG_INTEG_LIM  = 3'd5,
    REG_LOOP_MODE  = 3'd6
  } cfg_idx_t;

endpackage

// File: hdl/multimode_pid_controller_top.sv
// multimode fixed-point pid controller, top level
// depends on mpid_pkg and multimode_pid_controller_top_assert.svh
//
// One measured sample and one rate sample go in per transfer and one clamped
// drive value comes out per transfer. The error setpoint - measured is formed
// as the sample is captured; moving the sample on to the output register
// forms the mode's operands, updates the error history and the clamped
// error accumulator, runs the three gain multiplies (Q8.8, each product
// shifted right arithmetically by GAIN_FRAC_BITS), sums the terms and
// clamps to +/- drive_limit into that register, from which out_valid rises.
// A drive value held there for out_ready stalls the capture stage. A new sample
// is taken every cycle while out_ready stays high; while a finished drive
// value waits for out_ready the capture stage takes one more sample and then
// in_ready drops until the output is taken. The single pass through the gain
// multipliers and the accumulator update sets that rate. Modes: 0 incremental
// (the increment alone is output), 1 positional, 2 and 3 the trapezoidal
// variants of those, 4 position plus rate (history frozen, accumulator fed by
// the rate only when gain_i is nonzero); codes 5 to 7 run as incremental.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while no sample is in flight (the block itself does
// not enforce it); index 7 is ignored. Reset clears error history and accumulator.
module multimode_pid_controller_top
  import mpid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_W-1:0]     in_measured,
  input  logic signed [DATA_W-1:0]     in_measured_rate,
  // drive channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_W-1:0]     out_drive,
  // register write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // product of a 16 bit gain and the widest (accumulator) operand
  localparam int PROD_W = DATA_W + SUM_W;
  // three terms summed, two guard bits
  localparam int ACC_W  = PROD_W + 2;

  // configuration registers
  logic signed [DATA_W-1:0] setpoint_r;
  logic signed [DATA_W-1:0] gain_p_r;
  logic signed [DATA_W-1:0] gain_i_r;
  logic signed [DATA_W-1:0] gain_d_r;
  logic [DLIM_W-1:0]        drive_limit_r;
  logic [ILIM_W-1:0]        integral_limit_r;
  mode_t                    mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r       <= '0;
      gain_p_r         <= '0;
      gain_i_r         <= '0;
      gain_d_r         <= '0;
      drive_limit_r    <= DLIM_RST;
      integral_limit_r <= ILIM_RST;
      mode_r           <= MODE_INC;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SETPOINT:  setpoint_r       <= cfg_data[DATA_W-1:0];
        REG_GAIN_P:    gain_p_r         <= cfg_data[DATA_W-1:0];
        REG_GAIN_I:    gain_i_r         <= cfg_data[DATA_W-1:0];
        REG_GAIN_D:    gain_d_r         <= cfg_data[DATA_W-1:0];
        REG_DRIVE_LIM: drive_limit_r    <= cfg_data[DLIM_W-1:0];
        REG_INTEG_LIM: integral_limit_r <= cfg_data[ILIM_W-1:0];
        REG_LOOP_MODE: mode_r           <= mode_t'(cfg_data[MODE_W-1:0]);
        default: ;  // index beyond the register list
      endcase
    end
  end

  // pipeline handshake: capture stage then output register
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_xfer;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture stage: current error and rate sample
  logic signed [ERR_W-1:0]  s1_err_r;
  logic signed [DATA_W-1:0] s1_rate_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_err_r  <= ERR_W'({setpoint_r[DATA_W-1], setpoint_r})
                 - ERR_W'({in_measured[DATA_W-1], in_measured});
      s1_rate_r <= in_measured_rate;
    end
  end

  // error history and accumulator
  logic signed [ERR_W-1:0] err_prev_r, err_prev_nxt;
  logic signed [ERR_W-1:0] err_prev2_r, err_prev2_nxt;
  logic signed [SUM_W-1:0] err_sum_r, err_sum_nxt;

  // operand candidates
  logic signed [ERR_W:0]   diff1;     // e0 - e1
  logic signed [ERR_W+1:0] diff2;     // e0 - 2*e1 + e2
  logic signed [ERR_W:0]   pair_sum;  // e0 + e1
  logic signed [ERR_W-1:0] trap_avg;  // (e0 + e1) >>> 1
  logic signed [ERR_W-1:0] neg_rate;

  assign diff1    = {s1_err_r[ERR_W-1], s1_err_r} - {err_prev_r[ERR_W-1], err_prev_r};
  assign diff2    = {{2{s1_err_r[ERR_W-1]}}, s1_err_r}
                  - {err_prev_r[ERR_W-1], err_prev_r, 1'b0}
                  + {{2{err_prev2_r[ERR_W-1]}}, err_prev2_r};
  assign pair_sum = {s1_err_r[ERR_W-1], s1_err_r} + {err_prev_r[ERR_W-1], err_prev_r};
  assign trap_avg = pair_sum[ERR_W:1];
  assign neg_rate = -{s1_rate_r[DATA_W-1], s1_rate_r};

  // accumulator step, clamped to +/- integral_limit
  logic signed [SUM_W:0]   acc_inc;
  logic signed [SUM_W:0]   acc_raw;
  logic signed [SUM_W:0]   ilim;
  logic                    acc_en;

  assign ilim    = $signed({2'b00, integral_limit_r});
  assign acc_raw = {err_sum_r[SUM_W-1], err_sum_r} + acc_inc;

  always_comb begin
    acc_en  = 1'b0;
    acc_inc = '0;
    unique case (mode_r)
      MODE_POS: begin
        acc_en  = 1'b1;
        acc_inc = (SUM_W+1)'(s1_err_r);
      end
      MODE_TRAP_POS: begin
        acc_en  = 1'b1;
        acc_inc = (SUM_W+1)'(trap_avg);
      end
      MODE_POS_RATE: begin
        // rate only feeds the accumulator while the integral path is in use
        acc_en  = (gain_i_r != '0);
        acc_inc = (SUM_W+1)'(s1_rate_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    err_sum_nxt = err_sum_r;
    if (acc_en) begin
      priority if (acc_raw > ilim) begin
        err_sum_nxt = ilim[SUM_W-1:0];
      end else if (acc_raw < -ilim) begin
        err_sum_nxt = SUM_W'(-ilim);
      end else begin
        err_sum_nxt = acc_raw[SUM_W-1:0];
      end
    end
  end

  // history shifts except in position-rate mode
  always_comb begin
    err_prev_nxt  = s1_err_r;
    err_prev2_nxt = err_prev_r;
    if (mode_r == MODE_POS_RATE) begin
      err_prev_nxt  = err_prev_r;
      err_prev2_nxt = err_prev2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      err_sum_r   <= '0;
    end else if (s1_adv) begin
      err_prev_r  <= err_prev_nxt;
      err_prev2_r <= err_prev2_nxt;
      err_sum_r   <= err_sum_nxt;
    end
  end

  // gain operands per mode
  logic signed [ERR_W:0]   p_opd;
  logic signed [SUM_W-1:0] i_opd;
  logic signed [ERR_W+1:0] d_opd;

  always_comb begin
    unique case (mode_r)
      MODE_POS, MODE_TRAP_POS: begin
        p_opd = (ERR_W+1)'(s1_err_r);
        i_opd = err_sum_nxt;
        d_opd = (ERR_W+2)'(diff1);
      end
      MODE_TRAP_INC: begin
        p_opd = diff1;
        i_opd = SUM_W'(trap_avg);
        d_opd = diff2;
      end
      MODE_POS_RATE: begin
        // with gain_i at zero the integral term is zero whatever the operand
        p_opd = (ERR_W+1)'(s1_err_r);
        i_opd = err_sum_nxt;
        d_opd = (ERR_W+2)'(neg_rate);
      end
      default: begin
        // incremental, also the unused codes
        p_opd = diff1;
        i_opd = SUM_W'(s1_err_r);
        d_opd = diff2;
      end
    endcase
  end

  // gain products, each shifted on its own
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [PROD_W-1:0] term_p, term_i, term_d;
  logic signed [ACC_W-1:0]  drive_sum;
  logic signed [ACC_W-1:0]  dlim;
  logic signed [DATA_W-1:0] drive_nxt;

  assign prod_p = PROD_W'(gain_p_r) * PROD_W'(p_opd);
  assign prod_i = PROD_W'(gain_i_r) * PROD_W'(i_opd);
  assign prod_d = PROD_W'(gain_d_r) * PROD_W'(d_opd);

  assign term_p = prod_p >>> GAIN_FRAC_BITS;
  assign term_i = prod_i >>> GAIN_FRAC_BITS;
  assign term_d = prod_d >>> GAIN_FRAC_BITS;

  assign drive_sum = ACC_W'(term_p) + ACC_W'(term_i) + ACC_W'(term_d);
  assign dlim      = $signed({{(ACC_W-DLIM_W){1'b0}}, drive_limit_r});

  // symmetric clamp; drive_limit below 2^15 keeps the value in 16 bits
  always_comb begin
    priority if (drive_sum > dlim) begin
      drive_nxt = dlim[DATA_W-1:0];
    end else if (drive_sum < -dlim) begin
      drive_nxt = DATA_W'(-dlim);
    end else begin
      drive_nxt = drive_sum[DATA_W-1:0];
    end
  end

  logic signed [DATA_W-1:0] out_drive_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // checks
  `include "multimode_pid_controller_top_assert.svh"

  // a free output register always lets a sample in
  `MPID_ASSERT_NOW(a_ready_when_free, !out_valid_r || out_ready, in_ready)
  // a captured sample stays in the capture stage until it can move on
  `MPID_ASSERT_NEXT(a_capture_held, s1_valid_r && !s1_adv, s1_valid_r)
  // position-rate mode freezes the error history
  `MPID_ASSERT_NEXT(a_hist_frozen, s1_adv && mode_r == MODE_POS_RATE, $stable(err_prev_r))
  // a disabled accumulator step, as in the incremental modes, leaves the accumulator unchanged
  `MPID_ASSERT_NEXT(a_sum_idle, s1_adv && !acc_en, $stable(err_sum_r))

endmodule
